// ===== hw/rtl/pfba_pkg.sv =====
// pfba_pkg: shared types and constants of the page frame bitmap allocator
`timescale 1ns / 1ps

package pfba_pkg;

	localparam int unsigned FRAME_W        = 12;
	localparam int unsigned CFG_W          = 13;
	localparam int unsigned BYTE_IDX_W     = 9;
	localparam int unsigned BIT_IDX_W      = 3;
	localparam int unsigned BITS_PER_BYTE  = 8;
	localparam int unsigned MAX_FRAMES     = 4096;
	localparam int unsigned DEFAULT_FRAMES = 4096;
	localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;
	localparam logic [BITS_PER_BYTE-1:0] TOP_BIT = 8'h80;

	typedef enum logic [1:0] {
		MODE_ALLOC   = 2'd0,
		MODE_FREE    = 2'd1,
		MODE_RESERVE = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_WAS_FREE = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	// outcome of the first-free search over one bitmap byte
	typedef struct packed {
		logic                 found;
		logic [BIT_IDX_W-1:0] idx;
	} pick_t;

endpackage

// ===== hw/rtl/pfba_channels.sv =====
// pfba_channels: valid/ready interfaces for the request and response channels
`timescale 1ns / 1ps

interface pfba_req_if;
	import pfba_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [FRAME_W-1:0] frame;
	modport source (output valid, mode, frame, input ready);
	modport sink (input valid, mode, frame, output ready);
endinterface

interface pfba_rsp_if;
	import pfba_pkg::*;
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame_out;
	logic [1:0]         status;
	modport source (output valid, frame_out, status, input ready);
	modport sink (input valid, frame_out, status, output ready);
endinterface

// ===== hw/rtl/pfba_bit_pick.sv =====
// pfba_bit_pick: first free frame within one bitmap byte, honoring a partial last byte
`timescale 1ns / 1ps

module pfba_bit_pick (
	input  logic [pfba_pkg::BITS_PER_BYTE-1:0] byte_bits,
	input  logic                               last_byte,
	input  logic [pfba_pkg::BIT_IDX_W-1:0]     rem,
	output pfba_pkg::pick_t                    pick
);
	import pfba_pkg::*;

	logic [BITS_PER_BYTE-1:0] allowed;
	logic [BITS_PER_BYTE-1:0] free_bits;

	// frame i of the byte sits at bit 7-i
	always_comb begin
		for (int i = 0; i < BITS_PER_BYTE; i++) begin
			allowed[BITS_PER_BYTE-1-i] = !(last_byte && (rem != '0) &&
				(BIT_IDX_W'(i) >= rem));
		end
		free_bits = ~byte_bits & allowed;
	end

	// lowest frame wins, so walk downward and let it overwrite
	always_comb begin
		pick = '0;
		for (int i = BITS_PER_BYTE - 1; i >= 0; i--) begin
			if (free_bits[BITS_PER_BYTE-1-i]) begin
				pick.found = 1'b1;
				pick.idx   = BIT_IDX_W'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/page_frame_bitmap_allocator_core.sv =====
// page_frame_bitmap_allocator_core: bitmap page frame allocator around one byte-wide memory
`timescale 1ns / 1ps

//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  req     | in  | valid/ready      | mode (alloc/free/reserve/nop), frame
//  rsp     | out | valid/ready      | frame_out, status
//  cfg     | in  | cfg_we, no ready | cfg_wdata = frames_in_use
//
//  one transaction is worked at a time; the bitmap memory has one byte port
//  free/reserve of an in-range frame: read, modify-write, then out; nop and out-of-range go straight out
//  allocate: scans bytes starting from the hint; the scan streams one
//    byte read per cycle through the memory port and stops at the first free bit
//  after reset a clearing pass writes every byte to zero, one byte a cycle
//    (ceil(min(FRAMES, 4096) / 8) bytes, 512 by default); req is not ready meanwhile
//  a waiting response in the output register does not block the next accept

module page_frame_bitmap_allocator_core #(
	parameter int unsigned FRAMES = pfba_pkg::DEFAULT_FRAMES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pfba_req_if.sink                    req,
	pfba_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [pfba_pkg::CFG_W-1:0]  cfg_wdata
);
	import pfba_pkg::*;

	// frames actually backed by storage
	localparam int unsigned FRAME_CAP = (FRAMES < MAX_FRAMES) ? FRAMES : MAX_FRAMES;
	localparam int unsigned MEM_BYTES = (FRAME_CAP + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
	localparam int unsigned AW        = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	localparam logic [CFG_W-1:0] CAP_LIM = CFG_W'(FRAME_CAP);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
	localparam int unsigned NB_W = BYTE_IDX_W + 1;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ALLOC  = 5'b00100,
		ST_RMW    = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         cfg_q;
	logic [BYTE_IDX_W-1:0]    hint_q;
	logic [AW-1:0]            clr_q;

	// transaction being worked
	mode_t                    op_q;
	logic [FRAME_W-1:0]       frame_q;

	// scan issue side
	logic [BYTE_IDX_W-1:0]    scan_q;
	logic [NB_W-1:0]          issued_q;

	// scan evaluate side, in the cycle after the read
	logic                     pend_s1;
	logic [BYTE_IDX_W-1:0]    byte_s1;
	logic                     last_s1;

	// result waiting for the output register
	logic [FRAME_W-1:0]       res_frame_q;
	logic [1:0]               res_status_q;

	// output register
	logic                     rsp_valid_q;
	logic [FRAME_W-1:0]       rsp_frame_q;
	logic [1:0]               rsp_status_q;

	// bitmap storage
	logic [BITS_PER_BYTE-1:0] mem [MEM_BYTES];
	logic [BITS_PER_BYTE-1:0] rd_data_q;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [BITS_PER_BYTE-1:0] wr_data;

	// effective limit and covered bytes
	logic [CFG_W-1:0]         lim;
	logic [NB_W-1:0]          nbytes;
	logic [BYTE_IDX_W-1:0]    start_byte;
	logic [BYTE_IDX_W-1:0]    scan_next;
	logic                     issue;
	logic                     in_lim;
	logic [BYTE_IDX_W-1:0]    req_byte;
	logic [BITS_PER_BYTE-1:0] op_mask;
	logic                     op_bit_set;
	mode_t                    req_mode;
	pick_t                    pick;
	logic                     out_free;

	assign lim        = (cfg_q < CAP_LIM) ? cfg_q : CAP_LIM;
	assign nbytes     = NB_W'((lim + CFG_W'(BITS_PER_BYTE - 1)) >> BIT_IDX_W);
	assign start_byte = ({1'b0, hint_q} < nbytes) ? hint_q : '0;
	assign scan_next  = (({1'b0, scan_q} + NB_W'(1)) == nbytes) ? '0 : scan_q + 1'b1;
	assign req_mode   = mode_t'(req.mode);
	assign in_lim     = {1'b0, req.frame} < lim;
	assign req_byte   = req.frame[FRAME_W-1:BIT_IDX_W];
	assign op_mask    = TOP_BIT >> frame_q[BIT_IDX_W-1:0];
	assign op_bit_set = (rd_data_q & op_mask) != '0;
	assign out_free   = !rsp_valid_q || rsp.ready;

	// keep issuing reads until every covered byte has gone out or a hit is seen
	assign issue = (state_q == ST_ALLOC) && (issued_q < nbytes) && !(pend_s1 && pick.found);

	pfba_bit_pick u_pick (
		.byte_bits (rd_data_q),
		.last_byte ({1'b0, byte_s1} == (nbytes - NB_W'(1))),
		.rem       (lim[BIT_IDX_W-1:0]),
		.pick      (pick)
	);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = byte_s1[AW-1:0];
		wr_data = rd_data_q | (TOP_BIT >> pick.idx);
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				// free and reserve of an in-range frame fetch their byte as the transaction is accepted
				rd_en   = req.valid && in_lim &&
					(req_mode == MODE_FREE || req_mode == MODE_RESERVE);
				rd_addr = req_byte[AW-1:0];
			end
			ST_ALLOC: begin
				rd_en = issue;
				wr_en = pend_s1 && pick.found;
			end
			ST_RMW: begin
				wr_addr = frame_q[BIT_IDX_W +: AW];
				if (op_q == MODE_FREE) begin
					wr_en   = op_bit_set;
					wr_data = rd_data_q & ~op_mask;
				end else begin
					wr_en   = 1'b1;
					wr_data = rd_data_q | op_mask;
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			hint_q   <= '0;
			pend_s1  <= 1'b0;
			issued_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						frame_q     <= req.frame;
						op_q        <= req_mode;
						res_frame_q <= req.frame;
						unique case (req_mode)
							MODE_ALLOC: begin
								if (nbytes == '0) begin
									res_frame_q  <= '0;
									res_status_q <= STATUS_FULL;
									state_q      <= ST_FINISH;
								end else begin
									scan_q   <= start_byte;
									issued_q <= '0;
									state_q  <= ST_ALLOC;
								end
							end
							MODE_FREE: begin
								if (in_lim) begin
									hint_q  <= req_byte;
									state_q <= ST_RMW;
								end else begin
									res_status_q <= STATUS_WAS_FREE;
									state_q      <= ST_FINISH;
								end
							end
							MODE_RESERVE: begin
								res_status_q <= STATUS_OK;
								state_q      <= in_lim ? ST_RMW : ST_FINISH;
							end
							MODE_NOP: begin
								res_status_q <= STATUS_OK;
								state_q      <= ST_FINISH;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_ALLOC: begin
					if (issue) begin
						scan_q   <= scan_next;
						issued_q <= issued_q + 1'b1;
						byte_s1  <= scan_q;
						last_s1  <= issued_q == (nbytes - NB_W'(1));
					end
					pend_s1 <= issue;
					if (pend_s1 && pick.found) begin
						res_frame_q  <= {byte_s1, pick.idx};
						res_status_q <= STATUS_OK;
						pend_s1      <= 1'b0;
						state_q      <= ST_FINISH;
					end else if (pend_s1 && last_s1) begin
						// wrapped all the way round without a free bit
						res_frame_q  <= '0;
						res_status_q <= STATUS_FULL;
						pend_s1      <= 1'b0;
						state_q      <= ST_FINISH;
					end
				end
				ST_RMW: begin
					if (op_q == MODE_FREE) begin
						res_status_q <= op_bit_set ? STATUS_OK : STATUS_WAS_FREE;
					end else begin
						res_status_q <= STATUS_OK;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: loads when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			rsp_frame_q  <= res_frame_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign req.ready     = state_q == ST_IDLE;
	assign rsp.valid     = rsp_valid_q;
	assign rsp.frame_out = rsp_frame_q;
	assign rsp.status    = rsp_status_q;

	// sequencer stays one-hot
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	// scan never issues more reads than covered bytes
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC) |-> (issued_q <= nbytes))
		else $error("scan ran past the covered bytes");

	// evaluated byte always comes from a read issued the cycle before
	a_eval_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALLOC && pend_s1) |-> $past(rd_en))
		else $error("scan evaluated a byte that was never read");

	// a full map answers frame zero
	a_full_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q == STATUS_FULL) |-> (rsp_frame_q == '0))
		else $error("full response carries a nonzero frame");

	// no bitmap write while waiting for a transaction
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("bitmap written while idle");

endmodule
